FILE: rtl/lss_pkg.sv
// Shared types and constants of the line sensor scan sequencer.
// Holds item, result and command structs; no dependencies.
package lss_pkg;

	localparam int CH_W        = 3;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = 6;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int REG_IDX_W   = 1;
	localparam int REG_DATA_W  = 16;

	localparam logic [1:0] FUNC_POLL   = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [2:0] KIND_DESELECT = 3'd0;
	localparam logic [2:0] KIND_LED      = 3'd1;
	localparam logic [2:0] KIND_REQUEST  = 3'd2;
	localparam logic [2:0] KIND_DONE     = 3'd3;
	localparam logic [2:0] KIND_READ     = 3'd4;
	localparam logic [2:0] KIND_CLEARED  = 3'd5;

	localparam logic [REG_IDX_W-1:0] REG_SETTLE     = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_SAMPLE = 1'b1;

	localparam logic [15:0] SETTLE_RESET     = 16'd180;
	localparam logic [15:0] MAX_SAMPLE_RESET = 16'd4095;
	localparam logic [31:0] LED_BASE         = 32'h0101_0101;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] now_us;
		logic [15:0] adc_raw;
		logic        read_side;
		logic [4:0]  read_position;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] led_pattern;
		logic [2:0]  chip_select;
		logic [2:0]  adc_channel;
		logic        sensor_side;
		logic [7:0]  spi_command_byte;
		logic        frame_valid;
		logic        new_data;
		logic [15:0] read_value;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		OP_DESELECT,
		OP_LED,
		OP_REQUESTS,
		OP_FRAME,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [CH_W-1:0] ch;
		logic            frame_valid;
		logic            new_data;
		logic [15:0]     value;
	} cmd_t;

	typedef struct packed {
		logic              nonempty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

FILE: rtl/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/lss_front.sv
// Front part: accepts items, runs the scan phases and the sample store,
// and emits one command per item that yields results. Uses lss_pkg, lss_ram.
module lss_front
	import lss_pkg::*;
#(
	parameter int CHANNELS = 8,
	parameter int BLOCKS   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [REG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  item_t                 item,
	output logic                  full,
	input  qstat_t                qstat,
	output logic                  cmd_push,
	output cmd_t                  cmd
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEDS,
		PH_WAIT,
		PH_READ
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [CH_W-1:0]       step_q, step_d;
	logic [15:0]           wait_start_q, wait_start_d;
	logic [2:0]            reads_q, reads_d;
	logic                  over_q, over_d, over_next;
	logic                  new_flag_q, new_flag_d;
	logic [15:0]           settle_q, max_q;
	logic [STORE_DEPTH-1:0] valid_q;

	cmd_t                  cmd_s1, cmd_d;
	logic                  cmd_valid_s1;
	logic                  rd_valid_s1;

	logic                  accept, gen;
	logic [QCNT_W:0]       occupancy;
	logic [15:0]           swapped, elapsed, rdata;
	logic                  last_read, last_step, wr_en;
	logic [STORE_AW-1:0]   st_addr, rd_addr;

	// Count the command in flight toward the queue so it always finds room.
	assign occupancy = {1'b0, qstat.count} + (QCNT_W + 1)'(cmd_valid_s1);
	assign full      = occupancy >= (QCNT_W + 1)'(QDEPTH);
	assign accept    = push & ~full;

	assign swapped   = {item.adc_raw[7:0], item.adc_raw[15:8]};
	assign elapsed   = item.now_us - wait_start_q;
	assign over_next = over_q | (swapped > max_q);
	assign last_read = reads_q == 3'(2 * BLOCKS - 1);
	assign last_step = step_q == CH_W'(CHANNELS - 1);
	assign st_addr   = {reads_q[0], reads_q[2:1], step_q};
	assign rd_addr   = {item.read_side, item.read_position};

	always_comb begin
		phase_d          = phase_q;
		step_d           = step_q;
		wait_start_d     = wait_start_q;
		reads_d          = reads_q;
		over_d           = over_q;
		new_flag_d       = new_flag_q;
		gen              = 1'b0;
		wr_en            = 1'b0;
		cmd_d.op         = OP_DESELECT;
		cmd_d.ch         = step_q;
		cmd_d.frame_valid = 1'b0;
		cmd_d.new_data   = new_flag_q;
		cmd_d.value      = '0;
		if (accept) begin
			case (item.func)
				FUNC_READ: begin
					gen      = 1'b1;
					cmd_d.op = OP_READ;
				end
				FUNC_CLEAR: begin
					gen            = 1'b1;
					cmd_d.op       = OP_CLEAR;
					new_flag_d     = 1'b0;
					cmd_d.new_data = 1'b0;
				end
				FUNC_SAMPLE: begin
					if (phase_q == PH_READ) begin
						wr_en   = 1'b1;
						over_d  = over_next;
						reads_d = reads_q + 3'd1;
						if (last_read) begin
							reads_d = '0;
							step_d  = step_q + CH_W'(1);
							gen     = 1'b1;
							if (last_step) begin
								phase_d           = PH_IDLE;
								new_flag_d        = 1'b1;
								cmd_d.op          = OP_FRAME;
								cmd_d.new_data    = 1'b1;
								cmd_d.frame_valid = ~over_next;
							end else begin
								phase_d = PH_LEDS;
							end
						end
					end
				end
				default: begin
					case (phase_q)
						PH_IDLE: begin
							step_d  = '0;
							over_d  = 1'b0;
							phase_d = PH_LEDS;
							gen     = 1'b1;
						end
						PH_LEDS: begin
							wait_start_d = item.now_us;
							phase_d      = PH_WAIT;
							gen          = 1'b1;
							cmd_d.op     = OP_LED;
						end
						PH_WAIT: begin
							if (elapsed >= settle_q) begin
								reads_d  = '0;
								phase_d  = PH_READ;
								gen      = 1'b1;
								cmd_d.op = OP_REQUESTS;
							end
						end
						default: begin
						end
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			step_q       <= '0;
			wait_start_q <= '0;
			reads_q      <= '0;
			over_q       <= 1'b0;
			new_flag_q   <= 1'b0;
			settle_q     <= SETTLE_RESET;
			max_q        <= MAX_SAMPLE_RESET;
			valid_q      <= '0;
			cmd_valid_s1 <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			step_q       <= step_d;
			wait_start_q <= wait_start_d;
			reads_q      <= reads_d;
			over_q       <= over_d;
			new_flag_q   <= new_flag_d;
			cmd_valid_s1 <= gen;
			if (wr_en) begin
				valid_q[st_addr] <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SETTLE:     settle_q <= cfg_data;
					REG_MAX_SAMPLE: max_q    <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1      <= cmd_d;
		rd_valid_s1 <= valid_q[rd_addr];
	end

	lss_ram #(
		.WIDTH(16),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(st_addr),
		.wdata(swapped),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// Merge the registered store data; an entry never written reads as zero.
	always_comb begin
		cmd = cmd_s1;
		if (cmd_s1.op == OP_READ && rd_valid_s1) begin
			cmd.value = rdata;
		end
	end

	assign cmd_push = cmd_valid_s1;

endmodule

FILE: rtl/lss_cmd_queue.sv
// Short command queue between the front and back parts.
// Uses lss_pkg.
module lss_cmd_queue
	import lss_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   din,
	input  logic   pop,
	output cmd_t   dout,
	output qstat_t qstat
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout           = mem_q[rd_ptr_q];
	assign qstat.count    = count_q;
	assign qstat.nonempty = count_q != '0;

endmodule

FILE: rtl/lss_back.sv
// Back part: expands each queued command into its result words and holds
// the oldest one in the output register. Uses lss_pkg.
module lss_back
	import lss_pkg::*;
#(
	parameter int BLOCKS = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  qstat_t qstat,
	input  cmd_t   head,
	output logic   q_pop,
	output logic   empty,
	input  logic   pop,
	output res_t   result
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	res_t       out_q, res_d;
	logic       load;

	always_comb begin
		res_d          = '0;
		res_d.new_data = head.new_data;
		res_d.last     = 1'b1;
		case (head.op)
			OP_DESELECT: begin
				res_d.kind = KIND_DESELECT;
			end
			OP_LED: begin
				res_d.kind        = KIND_LED;
				res_d.led_pattern = LED_BASE << head.ch;
			end
			OP_REQUESTS: begin
				res_d.kind             = KIND_REQUEST;
				res_d.chip_select      = {1'b0, idx_q[2:1]} + 3'd1;
				res_d.adc_channel      = head.ch;
				res_d.sensor_side      = idx_q[0];
				res_d.spi_command_byte = {2'b00, head.ch, 3'b000};
				res_d.last             = idx_q == 3'(2 * BLOCKS - 1);
			end
			OP_FRAME: begin
				// deselect first, then the frame report
				if (idx_q == '0) begin
					res_d.kind = KIND_DESELECT;
					res_d.last = 1'b0;
				end else begin
					res_d.kind        = KIND_DONE;
					res_d.frame_valid = head.frame_valid;
				end
			end
			OP_READ: begin
				res_d.kind       = KIND_READ;
				res_d.read_value = head.value;
			end
			OP_CLEAR: begin
				res_d.kind = KIND_CLEARED;
			end
			default: begin
				res_d.kind = KIND_DESELECT;
			end
		endcase
	end

	assign load  = qstat.nonempty && (!out_valid_q || pop);
	assign q_pop = load && res_d.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= res_d.last ? 3'd0 : idx_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_d;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = out_q;

endmodule

FILE: rtl/line_sensor_scan_sequencer.sv
// Top level of the line sensor scan sequencer.
// Uses lss_pkg, lss_front, lss_cmd_queue, lss_back.
//
// Usage:
//   Items enter as a queue: drive item and push; the item is taken at an edge
//   with push high and full low. Results leave as a queue: while empty is low
//   the oldest result word sits on result; take it with pop.
//   Settings are written through cfg_we/cfg_index/cfg_data (0 settle time,
//   1 sample limit) while the block is idle; writes take effect at once.
// Path: an item's first result word passes the front stage, the command
//   queue and the output register; further words of the same item follow
//   one per cycle while each word is taken with pop.
// Throughput: one item per cycle on the input while the 4-entry command
//   queue has room; the back part drains one result word per cycle while
//   pop is high, so an item's eight read requests hold the output till taken.
// Stall: when pop stays low the output word holds, the back part stops,
//   the command queue fills, and full rises; items already taken are kept.
// Reset: all control state clears at once; the sample store reads back zero
//   for every entry not yet written (per-entry valid bits, no clearing pass).
module line_sensor_scan_sequencer
	import lss_pkg::*;
#(
	parameter int CHANNELS = 8,
	parameter int BLOCKS   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [REG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  item_t                 item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output res_t                  result
);

	qstat_t qstat;
	cmd_t   cmd_in, cmd_head;
	logic   cmd_push, cmd_pop;

	// Decode items, track the scan phase, own settings and sample store.
	lss_front #(
		.CHANNELS(CHANNELS),
		.BLOCKS  (BLOCKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (item),
		.full     (full),
		.qstat    (qstat),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Decouple the front from the result drain.
	lss_cmd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.din   (cmd_in),
		.pop   (cmd_pop),
		.dout  (cmd_head),
		.qstat (qstat)
	);

	// Expand commands into result words.
	lss_back #(
		.BLOCKS(BLOCKS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.head  (cmd_head),
		.q_pop (cmd_pop),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

`ifndef ASSERT_OFF
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QDEPTH))
		else $error("command queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (qstat.count < QCNT_W'(QDEPTH)))
		else $error("command pushed into a full queue");

	a_full_when_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.count == QCNT_W'(QDEPTH)) |-> full)
		else $error("input open while command queue is full");

	a_chip_select: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_REQUEST) |->
		(result.chip_select != 3'd0 && result.chip_select <= 3'(BLOCKS)))
		else $error("read request with chip select out of range");
`endif

endmodule

FILE: verif/lss_scan_model_pkg.sv
// Scoreboard for the line sensor scan sequencer test: scan state, predictor, expected words.
// Depends on lss_pkg for the item and result word types and the code constants.
package lss_scan_model_pkg;
	import lss_pkg::*;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_LEDS,
		SCAN_WAIT,
		SCAN_READ
	} scan_state_t;

	class scan_scoreboard;
		// settings mirrored from the register writes
		logic [15:0] settle;
		logic [15:0] limit;

		scan_state_t phase;
		logic [2:0]  step;
		logic [15:0] wait_start;
		logic [2:0]  reads_done;
		logic [15:0] samples [64];
		logic        over_limit;
		logic        new_data;

		res_t expected_words [$];
		int   errors;
		int   items_taken;
		int   words_checked;
		int   scans_done;

		function new();
			settle     = SETTLE_RESET;
			limit      = MAX_SAMPLE_RESET;
			phase      = SCAN_IDLE;
			step       = '0;
			wait_start = '0;
			reads_done = '0;
			over_limit = 1'b0;
			new_data   = 1'b0;
			foreach (samples[i])
				samples[i] = '0;
			errors        = 0;
			items_taken   = 0;
			words_checked = 0;
			scans_done    = 0;
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction

		// Zeroed result word; new_data reflects the flag after the item.
		function res_t blank(logic [2:0] kind, logic last);
			res_t r;
			r          = '0;
			r.kind     = kind;
			r.new_data = new_data;
			r.last     = last;
			return r;
		endfunction

		function void accept_item(item_t w);
			res_t        r;
			logic [15:0] swapped;
			logic [15:0] elapsed;
			items_taken++;
			case (w.func)
				FUNC_READ: begin
					r            = blank(KIND_READ, 1'b1);
					r.read_value = samples[{w.read_side, w.read_position}];
					expected_words.push_back(r);
				end
				FUNC_CLEAR: begin
					new_data = 1'b0;
					expected_words.push_back(blank(KIND_CLEARED, 1'b1));
				end
				FUNC_SAMPLE: begin
					if (phase == SCAN_READ) begin
						swapped = {w.adc_raw[7:0], w.adc_raw[15:8]};
						samples[{reads_done[0], reads_done[2:1], step}] = swapped;
						if (swapped > limit)
							over_limit = 1'b1;
						reads_done = reads_done + 3'd1;
						if (reads_done == 3'd0) begin
							step = step + 3'd1;
							if (step == 3'd0) begin
								phase    = SCAN_IDLE;
								new_data = 1'b1;
								expected_words.push_back(blank(KIND_DESELECT, 1'b0));
								r             = blank(KIND_DONE, 1'b1);
								r.frame_valid = !over_limit;
								expected_words.push_back(r);
								scans_done++;
							end else begin
								phase = SCAN_LEDS;
								expected_words.push_back(blank(KIND_DESELECT, 1'b1));
							end
						end
					end
				end
				default: begin
					case (phase)
						SCAN_IDLE: begin
							step       = '0;
							over_limit = 1'b0;
							phase      = SCAN_LEDS;
							expected_words.push_back(blank(KIND_DESELECT, 1'b1));
						end
						SCAN_LEDS: begin
							wait_start    = w.now_us;
							phase         = SCAN_WAIT;
							r             = blank(KIND_LED, 1'b1);
							r.led_pattern = LED_BASE << step;
							expected_words.push_back(r);
						end
						SCAN_WAIT: begin
							elapsed = w.now_us - wait_start;
							if (elapsed >= settle) begin
								for (int b = 1; b <= 4; b++) begin
									for (int s = 0; s < 2; s++) begin
										r                  = blank(KIND_REQUEST,
											b == 4 && s == 1);
										r.chip_select      = 3'(b);
										r.adc_channel      = step;
										r.sensor_side      = 1'(s);
										r.spi_command_byte = {2'b00, step, 3'b000};
										expected_words.push_back(r);
									end
								end
								reads_done = '0;
								phase      = SCAN_READ;
							end
						end
						default: ;
					endcase
				end
			endcase
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_word(res_t got);
			res_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected result word, kind %0d", got.kind));
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (got.kind !== want.kind)
				report($sformatf("kind %0h, want %0h", got.kind, want.kind));
			if (got.led_pattern !== want.led_pattern)
				report($sformatf("led_pattern %0h, want %0h", got.led_pattern,
					want.led_pattern));
			if (got.chip_select !== want.chip_select)
				report($sformatf("chip_select %0h, want %0h", got.chip_select,
					want.chip_select));
			if (got.adc_channel !== want.adc_channel)
				report($sformatf("adc_channel %0h, want %0h", got.adc_channel,
					want.adc_channel));
			if (got.sensor_side !== want.sensor_side)
				report($sformatf("sensor_side %0h, want %0h", got.sensor_side,
					want.sensor_side));
			if (got.spi_command_byte !== want.spi_command_byte)
				report($sformatf("spi_command_byte %0h, want %0h", got.spi_command_byte,
					want.spi_command_byte));
			if (got.frame_valid !== want.frame_valid)
				report($sformatf("frame_valid %0h, want %0h", got.frame_valid,
					want.frame_valid));
			if (got.new_data !== want.new_data)
				report($sformatf("new_data %0h, want %0h", got.new_data, want.new_data));
			if (got.read_value !== want.read_value)
				report($sformatf("read_value %0h, want %0h", got.read_value,
					want.read_value));
			if (got.last !== want.last)
				report($sformatf("last %0h, want %0h", got.last, want.last));
		endtask
	endclass

endpackage

FILE: verif/line_sensor_scan_sequencer_test.sv
// Self-checking test of line_sensor_scan_sequencer: directed scan steps, then random scans.
// Depends on lss_pkg and lss_scan_model_pkg (scoreboard with its own scan predictor).
module line_sensor_scan_sequencer_test
	import lss_pkg::*, lss_scan_model_pkg::*;
	();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_WORDS  = 60;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = REG_SETTLE;
	logic [REG_DATA_W-1:0] cfg_data  = '0;
	logic                  push      = 1'b0;
	item_t                 item      = '0;
	logic                  full;
	logic                  empty;
	logic                  pop       = 1'b0;
	res_t                  result;

	scan_scoreboard sb = new();

	// calm: no idling on either side in the closing part of the run
	bit clean_scan = 1'b0;
	bit calm       = 1'b0;
	int stall_left = 0;
	int cycles     = 0;

	line_sensor_scan_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (item),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	always #2 clk = ~clk;

	// Watchdog: a correct run ends far below this count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: check the word taken at this edge, then decide pop for the
	// next cycle. Stalls come in bursts of random length.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_word(result);
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				pop        <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(0, 17);
				pop        <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic item_t word(logic [1:0] func, logic [15:0] now_us,
		logic [15:0] adc_raw, logic side, logic [4:0] position);
		item_t w;
		w.func          = func;
		w.now_us        = now_us;
		w.adc_raw       = adc_raw;
		w.read_side     = side;
		w.read_position = position;
		return w;
	endfunction

	// Offer one word and hold it until the block takes it. A sender gap, when
	// drawn, drops push first so gaps land on every phase of a scan.
	task automatic push_word(input item_t w);
		if (!calm && $urandom_range(0, 9) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item <= w;
		push <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
		sb.accept_item(w);
	endtask

	// Stop sending and wait until every expected word has come out, then let
	// the pipeline settle for words that cause no result.
	task automatic drain_results();
		push <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [15:0] settle, input logic [15:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SETTLE;
		cfg_data  <= settle;
		@(posedge clk);
		cfg_index <= REG_MAX_SAMPLE;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.settle = settle;
		sb.limit  = limit;
	endtask

	// Build the next random word. Most words follow the scan: polls that move
	// it along, wait polls around the settle boundary, and samples mostly within
	// the limit, some at it or past it. The rest are read-backs, clears and raw noise.
	task automatic pick_word(output item_t w);
		logic [15:0] delta;
		logic [15:0] v;
		w = word(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
			1'($urandom), 5'($urandom));
		if ($urandom_range(0, 99) < 15)
			return;
		if ($urandom_range(0, 9) == 0) begin
			w.func = $urandom_range(0, 1) ? FUNC_READ : FUNC_CLEAR;
			return;
		end
		case (sb.phase)
			SCAN_READ: begin
				w.func = FUNC_SAMPLE;
				if (clean_scan || $urandom_range(0, 3) != 0) begin
					v = 16'($urandom_range(0, sb.limit));
				end else begin
					case ($urandom_range(0, 3))
						0: v = sb.limit;
						1: v = sb.limit + 16'd1;
						default: v = 16'($urandom);
					endcase
				end
				// first SPI byte lands in the low half, so swap before sending
				w.adc_raw = {v[7:0], v[15:8]};
			end
			SCAN_WAIT: begin
				w.func = FUNC_POLL;
				case ($urandom_range(0, 3))
					0: delta = sb.settle - 16'd1;
					1: delta = sb.settle;
					2: delta = 16'($urandom_range(sb.settle, 16'hFFFF));
					default: delta = 16'($urandom_range(0, sb.settle));
				endcase
				w.now_us = sb.wait_start + delta;
			end
			default: begin
				// a scan is about to start: pick whether it stays within the limit
				if (sb.phase == SCAN_IDLE)
					clean_scan = 1'($urandom_range(0, 1));
				w.func = FUNC_POLL;
			end
		endcase
	endtask

	task automatic run_random();
		item_t w;
		for (int k = 0; k < PHASE_WORDS; k++) begin
			pick_word(w);
			push_word(w);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Read-back of both store corners before anything is written, then clear.
		push_word(word(FUNC_READ, 16'h0000, 16'h0000, 1'b0, 5'd0));
		push_word(word(FUNC_READ, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31));
		push_word(word(FUNC_CLEAR, 16'h0000, 16'h0000, 1'b0, 5'd0));
		// A sample outside the reading phase is dropped.
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, 5'd0));
		push_word(word(FUNC_POLL, 16'h0000, 16'h0000, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h1234, 16'hABCD, 1'b1, 5'd7));
		// Light step 0 just below the tick wrap so the settle check wraps.
		push_word(word(FUNC_POLL, 16'hFFF0, 16'h0000, 1'b0, 5'd0));
		push_word(word(FUNC_POLL, 16'hFFF0 + 16'd179, 16'h0000, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'h5555, 1'b0, 5'd0));
		push_word(word(FUNC_POLL, 16'hFFF0 + 16'd180, 16'h0000, 1'b0, 5'd0));
		// A poll while reading is dropped.
		push_word(word(FUNC_POLL, 16'hFFFF, 16'h0000, 1'b0, 5'd0));
		// Eight samples: zero, the limit, one past it, all ones, and filler.
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'h0000, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'hFF0F, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'h0010, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'h3412, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'h00FF, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'hAA55, 1'b0, 5'd0));
		push_word(word(FUNC_SAMPLE, 16'h0000, 16'h0102, 1'b0, 5'd0));
		// Read back the first and the last sample of the step, then clear.
		push_word(word(FUNC_READ, 16'h0000, 16'h0000, 1'b0, 5'd0));
		push_word(word(FUNC_READ, 16'h0000, 16'h0000, 1'b1, 5'd24));
		push_word(word(FUNC_CLEAR, 16'h0000, 16'h0000, 1'b0, 5'd0));
		drain_results();

		// Random scans under reset settings, both extremes, then a random pair.
		run_random();
		drain_results();
		write_settings(16'h0000, 16'h0000);
		run_random();
		drain_results();
		write_settings(16'hFFFF, 16'hFFFF);
		run_random();
		drain_results();
		write_settings(16'($urandom_range(1, 600)), 16'($urandom_range(200, 60000)));
		calm = 1'b1;
		run_random();
		drain_results();

		$display("covered %0d input words over four settings, %0d result words checked",
			sb.items_taken, sb.words_checked);
		$display("completed %0d full scans", sb.scans_done);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
